// ----- hdl/qsu_pkg.sv -----
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and constants of the quoted string unescaper.
// ----------------------------------------------------------------------------
package qsu_pkg;

	// Default number of hex digits that one x escape may carry (1 to 4).
	localparam int MAX_HEX_DIGITS_DEF = 4;

	// Reset value of the escape limit register.
	localparam logic [7:0] ESCAPE_LIMIT_RESET = 8'd127;

	// Register indexes of the configuration port.
	localparam int REG_ESCAPE_LIMIT = 0;
	localparam int APB_ADDR_W       = 3;
	localparam int APB_DATA_W       = 32;

	// Results that one input word can cause, and depth of the result queue.
	localparam int RES_SLOTS   = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} res_t;

	// All results of one input word, in output order; last_idx names the final one.
	typedef struct packed {
		res_t [RES_SLOTS-1:0] slot;
		logic [1:0]           last_idx;
	} bundle_t;

endpackage

// ----- hdl/qsu_if.sv -----
// ----------------------------------------------------------------------------
// qsu_in_if / qsu_out_if
// Valid/ready channels for raw input words and decoded result words.
// ----------------------------------------------------------------------------
interface qsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface qsu_out_if
	import qsu_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	kind_t      kind;
	logic       run_last;

	modport source (output valid, output out_byte, output kind, output run_last, input ready);
	modport sink (input valid, input out_byte, input kind, input run_last, output ready);
endinterface

// ----- hdl/qsu_front.sv -----
// ----------------------------------------------------------------------------
// qsu_front
// Scanner: takes one raw word per cycle unless the queue is full, tracks quote
// and escape state and builds the bundle of results that the word causes.
// ----------------------------------------------------------------------------
module qsu_front
	import qsu_pkg::*;
#(
	parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qsu_in_if.sink      byte_stream,
	input  logic [7:0]  escape_limit,
	input  logic        full,
	output logic        push,
	output bundle_t     bundle
);

	localparam int AW   = 4 * MAX_HEX_DIGITS;
	localparam int CW   = (AW > 8) ? AW : 8;
	localparam int CNTW = $clog2(MAX_HEX_DIGITS + 1);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	typedef enum logic [3:0] {
		MODE_OUT = 4'b0001,
		MODE_IN  = 4'b0010,
		MODE_ESC = 4'b0100,
		MODE_HEX = 4'b1000
	} mode_t;

	mode_t             mode_q, mode_n;
	logic [CNTW-1:0]   cnt_q, cnt_n;
	logic [AW-1:0]     acc_q, acc_n, acc_dig;
	logic              halt_q, halt_n;

	logic [7:0]        c;
	logic              accept;
	logic              is_hex;
	logic [3:0]        dig;
	logic              esc_known;
	logic [7:0]        esc_val;
	logic              do_inside;
	logic              fin;
	logic [AW-1:0]     fin_val;
	logic [1:0]        n;

	assign c      = byte_stream.in_byte;
	assign byte_stream.ready = !full;
	assign accept = byte_stream.valid && !full;

	always_comb begin
		is_hex = 1'b1;
		dig    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			dig = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			dig = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			dig = 4'(c - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		esc_known = 1'b1;
		unique case (c)
			8'h62:    esc_val = 8'h08;
			8'h74:    esc_val = 8'h09;
			8'h6E:    esc_val = 8'h0A;
			8'h66:    esc_val = 8'h0C;
			8'h72:    esc_val = 8'h0D;
			CH_QUOTE: esc_val = CH_QUOTE;
			CH_APOS:  esc_val = CH_APOS;
			CH_BSL:   esc_val = CH_BSL;
			default: begin
				esc_val   = 8'h00;
				esc_known = 1'b0;
			end
		endcase
	end

	assign acc_dig = (acc_q << 4) | AW'(dig);

	// Results are appended to the bundle in order; n counts them.
	always_comb begin
		mode_n    = mode_q;
		cnt_n     = cnt_q;
		acc_n     = acc_q;
		halt_n    = halt_q;
		bundle    = '0;
		n         = 2'd0;
		do_inside = 1'b0;
		fin       = 1'b0;
		fin_val   = '0;

		if (!halt_q) begin
			unique case (mode_q)
				MODE_OUT: begin
					if (c == CH_QUOTE) mode_n = MODE_IN;
				end
				MODE_IN: begin
					do_inside = 1'b1;
				end
				MODE_ESC: begin
					if (c == CH_LX || c == CH_UX) begin
						mode_n = MODE_HEX;
						cnt_n  = '0;
						acc_n  = '0;
					end else if (esc_known) begin
						bundle.slot[n].data = esc_val;
						bundle.slot[n].kind = KIND_BYTE;
						n = n + 2'd1;
						mode_n = MODE_IN;
					end else begin
						bundle.slot[n].kind = KIND_ERROR;
						n = n + 2'd1;
						halt_n = 1'b1;
					end
				end
				MODE_HEX: begin
					if (is_hex) begin
						acc_n = acc_dig;
						cnt_n = cnt_q + CNTW'(1);
						if (cnt_n == CNTW'(MAX_HEX_DIGITS)) begin
							fin     = 1'b1;
							fin_val = acc_dig;
						end
					end else if (cnt_q == '0) begin
						bundle.slot[n].kind = KIND_ERROR;
						n = n + 2'd1;
						halt_n = 1'b1;
					end else begin
						fin       = 1'b1;
						fin_val   = acc_q;
						do_inside = 1'b1;
					end
				end
				default: begin
					mode_n = MODE_OUT;
				end
			endcase
		end

		if (fin) begin
			cnt_n  = '0;
			acc_n  = '0;
			mode_n = MODE_IN;
			if (CW'(fin_val) > CW'(escape_limit)) begin
				bundle.slot[n].kind = KIND_ERROR;
				n = n + 2'd1;
				halt_n    = 1'b1;
				do_inside = 1'b0;
			end else begin
				bundle.slot[n].data = 8'(fin_val);
				bundle.slot[n].kind = KIND_BYTE;
				n = n + 2'd1;
			end
		end

		if (do_inside) begin
			if (c == CH_BSL) begin
				mode_n = MODE_ESC;
			end else if (c == CH_QUOTE) begin
				mode_n = MODE_OUT;
			end else begin
				bundle.slot[n].data = c;
				bundle.slot[n].kind = KIND_BYTE;
				n = n + 2'd1;
			end
		end

		if (byte_stream.end_of_input) begin
			// A backslash or hex escape left open at the end of the token.
			if (!halt_n) begin
				if (mode_n == MODE_ESC || (mode_n == MODE_HEX && cnt_n == '0)) begin
					bundle.slot[n].kind = KIND_ERROR;
					n = n + 2'd1;
				end else if (mode_n == MODE_HEX) begin
					if (CW'(acc_n) > CW'(escape_limit)) begin
						bundle.slot[n].kind = KIND_ERROR;
					end else begin
						bundle.slot[n].data = 8'(acc_n);
						bundle.slot[n].kind = KIND_BYTE;
					end
					n = n + 2'd1;
				end
			end
			bundle.slot[n].kind = KIND_END;
			n = n + 2'd1;
			mode_n = MODE_OUT;
			cnt_n  = '0;
			acc_n  = '0;
			halt_n = 1'b0;
		end

		bundle.last_idx = n - 2'd1;
	end

	assign push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUT;
			cnt_q  <= '0;
			acc_q  <= '0;
			halt_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			acc_q  <= acc_n;
			halt_q <= halt_n;
		end
	end

endmodule

// ----- hdl/qsu_fifo.sv -----
// ----------------------------------------------------------------------------
// qsu_fifo
// Short queue of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module qsu_fifo
	import qsu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output logic    empty,
	output logic    full
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	bundle_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PW:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ----- hdl/qsu_back.sv -----
// ----------------------------------------------------------------------------
// qsu_back
// Output stage: while the receiver takes words, walks the head bundle one
// result per cycle into a registered output word.
// ----------------------------------------------------------------------------
module qsu_back
	import qsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        empty,
	output logic        pop,
	qsu_out_if.source   result_stream
);

	logic       out_valid_q;
	res_t       out_res_q;
	logic       out_last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_last;

	assign load    = !empty && (!out_valid_q || result_stream.ready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	assign result_stream.valid    = out_valid_q;
	assign result_stream.out_byte = out_res_q.data;
	assign result_stream.kind     = out_res_q.kind;
	assign result_stream.run_last = out_last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= head.slot[idx_q];
			out_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ----- hdl/quoted_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// Keeps the quoted text of a byte stream and decodes backslash escapes.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle whenever its four-entry result
// queue has room; the scanner decodes each word combinationally and writes
// the results it causes, up to three, into the queue as one bundle. The output
// stage sends one result word per cycle from a register while the receiver is
// ready, and the sustained rate is one input word per cycle as long as words
// average at most one result. The results of an accepted word pass through
// the queue and then the output register. The escape limit register lives at
// address 0 of the configuration port.
module quoted_string_unescaper
	import qsu_pkg::*;
#(
	parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	qsu_in_if.sink                 byte_stream,
	qsu_out_if.source              result_stream
);

	logic [7:0] escape_limit_q;
	logic       reg_hit;
	logic       push, pop, empty, full;
	bundle_t    push_data, head;

	// Word address decode: the register index sits above the byte offset.
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_ESCAPE_LIMIT));
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_DATA_W'(escape_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_limit_q <= ESCAPE_LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			escape_limit_q <= pwdata[7:0];
		end
	end

	qsu_front #(
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_stream  (byte_stream),
		.escape_limit (escape_limit_q),
		.full         (full),
		.push         (push),
		.bundle       (push_data)
	);

	qsu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	qsu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.result_stream (result_stream)
	);

endmodule

// ----- tb/qsu_decode_monitor.sv -----
// ----------------------------------------------------------------------------
// qsu_decode_monitor
// Watches both streams of the unescaper, predicts each result word and
// compares it with what the block sends.
// ----------------------------------------------------------------------------
// Every accepted input word runs through a behavioral decoder that keeps its
// own scan state and escape limit. The limit follows writes seen on the
// configuration port. The result words that a byte should cause are queued,
// and each result word taken from the block is checked against the oldest.
module qsu_decode_monitor
	import qsu_pkg::*;
#(
	parameter int HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	qsu_in_if                     byte_stream,
	qsu_out_if                    result_stream,
	output int                    failures,
	output int                    outstanding
);

	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_RETURN    = 8'h0D;

	typedef enum logic [1:0] {
		SCAN_OUTSIDE,
		SCAN_QUOTED,
		SCAN_ESCAPE,
		SCAN_HEX
	} scan_t;

	typedef struct {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} decoded_t;

	scan_t      scan;
	logic [2:0] digits_seen;
	logic [15:0] hex_sum;
	logic       halted;
	logic [7:0] limit_reg;
	decoded_t   expected_words[$];

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic void push_result(input logic [7:0] data, input kind_t kind);
		decoded_t w;
		w.data = data;
		w.kind = kind;
		w.last = 1'b0;
		expected_words = {expected_words, w};
	endfunction

	function automatic void flag_escape_error();
		halted = 1'b1;
		push_result(8'h00, KIND_ERROR);
	endfunction

	function automatic void close_hex_escape();
		logic [15:0] v;
		v = hex_sum;
		digits_seen = '0;
		hex_sum = '0;
		scan = SCAN_QUOTED;
		if (v > {8'h00, limit_reg})
			flag_escape_error();
		else
			push_result(v[7:0], KIND_BYTE);
	endfunction

	function automatic void take_quoted(input logic [7:0] c);
		if (c == "\\")
			scan = SCAN_ESCAPE;
		else if (c == "\"")
			scan = SCAN_OUTSIDE;
		else
			push_result(c, KIND_BYTE);
	endfunction

	function automatic void take_escape(input logic [7:0] c);
		logic [7:0] v;
		logic       simple;
		simple = 1'b1;
		v = c;
		case (c)
			"b": v = CH_BACKSPACE;
			"t": v = CH_TAB;
			"n": v = CH_NEWLINE;
			"f": v = CH_FORMFEED;
			"r": v = CH_RETURN;
			"\"", "'", "\\": v = c;
			"x", "X": begin
				simple = 1'b0;
				scan = SCAN_HEX;
				digits_seen = '0;
				hex_sum = '0;
			end
			default: begin
				simple = 1'b0;
				flag_escape_error();
			end
		endcase
		if (simple) begin
			scan = SCAN_QUOTED;
			push_result(v, KIND_BYTE);
		end
	endfunction

	function automatic void take_hex_digit(input logic [7:0] c);
		int d;
		d = nibble_of(c);
		if (d >= 0) begin
			hex_sum = {hex_sum[11:0], 4'(d)};
			digits_seen = digits_seen + 3'd1;
			if (int'(digits_seen) >= HEX_DIGITS)
				close_hex_escape();
		end else if (digits_seen == 0) begin
			flag_escape_error();
		end else begin
			// The byte that ended the escape is decoded as ordinary quoted text.
			close_hex_escape();
			if (!halted)
				take_quoted(c);
		end
	endfunction

	function automatic void decode_word(input logic [7:0] c, input logic eoi);
		int first;
		first = expected_words.size();
		if (!halted) begin
			case (scan)
				SCAN_OUTSIDE: if (c == "\"") scan = SCAN_QUOTED;
				SCAN_QUOTED:  take_quoted(c);
				SCAN_ESCAPE:  take_escape(c);
				default:      take_hex_digit(c);
			endcase
		end
		if (eoi) begin
			if (!halted) begin
				if (scan == SCAN_ESCAPE)
					flag_escape_error();
				else if (scan == SCAN_HEX) begin
					if (digits_seen == 0)
						flag_escape_error();
					else
						close_hex_escape();
				end
			end
			push_result(8'h00, KIND_END);
			scan = SCAN_OUTSIDE;
			digits_seen = '0;
			hex_sum = '0;
			halted = 1'b0;
		end
		if (expected_words.size() > first)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			scan = SCAN_OUTSIDE;
			digits_seen = '0;
			hex_sum = '0;
			halted = 1'b0;
			limit_reg = ESCAPE_LIMIT_RESET;
			expected_words.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready
					&& paddr == APB_ADDR_W'(REG_ESCAPE_LIMIT * 4))
				limit_reg = pwdata[7:0];
			if (byte_stream.valid && byte_stream.ready)
				decode_word(byte_stream.in_byte, byte_stream.end_of_input);
			if (result_stream.valid && result_stream.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word: data=%h kind=%0d last=%b",
						$time, result_stream.out_byte, result_stream.kind,
						result_stream.run_last);
					failures++;
				end else begin
					want = expected_words.pop_front();
					if (result_stream.out_byte !== want.data || result_stream.kind !== want.kind
							|| result_stream.run_last !== want.last) begin
						$display("%0t: mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
							$time, want.data, want.kind, want.last, result_stream.out_byte,
							result_stream.kind, result_stream.run_last);
						failures++;
					end
				end
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- tb/tb_quoted_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// tb_quoted_string_unescaper
// Stimulus and verdict for the quoted string unescaper.
// ----------------------------------------------------------------------------
// A short directed run covers the escape error paths and the hex escape
// endings. Random tokens follow, mostly well-formed quoted text with plain
// bytes, simple escapes and hex escapes, the rest noise. The escape limit is
// changed between phases while the block is idle. Both streams stall at
// random, the receiver once holds off long enough to back the block up, and
// the last phase runs at full rate. The monitor does all checking.
module tb_quoted_string_unescaper;
	import qsu_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 10;
	// Letters that form a simple escape after a backslash.
	localparam logic [63:0] ESCAPE_LETTERS = "btnfr\"'\\";

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	qsu_in_if  byte_stream ();
	qsu_out_if result_stream ();

	int         failures;
	int         outstanding;
	int         words_sent = 0;
	int         quiet_cycles = 0;
	bit         send_gaps = 1'b0;
	bit         recv_gaps = 1'b0;
	bit         hold_request = 1'b0;
	logic [7:0] limit_now = ESCAPE_LIMIT_RESET;
	logic [7:0] token_bytes[$];

	quoted_string_unescaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.byte_stream   (byte_stream),
		.result_stream (result_stream)
	);

	qsu_decode_monitor decode_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.byte_stream   (byte_stream),
		.result_stream (result_stream),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Nothing accepted on either stream for too long means the block hung.
	always @(posedge clk) begin
		if ((byte_stream.valid && byte_stream.ready)
				|| (result_stream.valid && result_stream.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		result_stream.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_stream.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
				result_stream.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result_stream.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eoi);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			byte_stream.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		byte_stream.valid        <= 1'b1;
		byte_stream.in_byte      <= b;
		byte_stream.end_of_input <= eoi;
		do @(posedge clk); while (!byte_stream.ready);
		words_sent++;
	endtask

	task automatic send_text(input string s, input logic eoi_at_end);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], eoi_at_end && i == s.len() - 1);
	endtask

	task automatic send_token();
		foreach (token_bytes[i])
			send_word(token_bytes[i], i == token_bytes.size() - 1);
	endtask

	// Stops offering words and waits until every predicted result has come,
	// then lets a word still in flight that causes no result drain.
	task automatic wait_results();
		byte_stream.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(REG_ESCAPE_LIMIT * 4);
		pwdata  <= {24'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		limit_now = v;
	endtask

	function automatic void append_byte(input logic [7:0] c);
		token_bytes = {token_bytes, c};
	endfunction

	function automatic logic [7:0] hex_letter(input int d);
		if (d < 10) return 8'(int'("0") + d);
		if ($urandom_range(0, 1) != 0) return 8'(int'("A") + d - 10);
		return 8'(int'("a") + d - 10);
	endfunction

	function automatic logic [7:0] outside_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == "\"");
		return c;
	endfunction

	function automatic void add_piece();
		logic [7:0] c;
		int         v;
		int         ndig;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				do c = 8'($urandom_range(0, 255)); while (c == "\"" || c == "\\");
				append_byte(c);
			end
			4, 5, 6: begin
				append_byte("\\");
				append_byte(ESCAPE_LETTERS[8 * $urandom_range(0, 7) +: 8]);
			end
			7, 8: begin
				// Mostly values the current limit accepts, now and then anything.
				if ($urandom_range(0, 7) != 0)
					v = $urandom_range(0, limit_now);
				else
					v = $urandom_range(0, 16'hFFFF);
				ndig = (v < 16) ? 1 : (v < 256) ? 2 : (v < 4096) ? 3 : 4;
				ndig = $urandom_range(ndig, MAX_HEX_DIGITS_DEF);
				c = "x";
				if ($urandom_range(0, 1) != 0)
					c = "X";
				append_byte("\\");
				append_byte(c);
				for (int i = ndig - 1; i >= 0; i--)
					append_byte(hex_letter((v >> (4 * i)) & 15));
			end
			default: begin
				append_byte("\"");
				append_byte(outside_byte());
				append_byte("\"");
			end
		endcase
	endfunction

	function automatic void build_clean_token();
		token_bytes.delete();
		repeat ($urandom_range(0, 2)) append_byte(outside_byte());
		append_byte("\"");
		repeat ($urandom_range(1, 8)) add_piece();
		if ($urandom_range(0, 2) != 0) begin
			append_byte("\"");
			repeat ($urandom_range(0, 2)) append_byte(outside_byte());
		end
	endfunction

	function automatic void build_noise_token();
		logic [7:0] c;
		token_bytes.delete();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 7))
				0, 1:    c = "\"";
				2, 3:    c = "\\";
				4:       c = "x";
				default: c = 8'($urandom_range(0, 255));
			endcase
			append_byte(c);
		end
	endfunction

	task automatic run_random(input int count);
		int target;
		target = words_sent + count;
		while (words_sent < target) begin
			if ($urandom_range(0, 3) == 0)
				build_noise_token();
			else
				build_clean_token();
			send_token();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		byte_stream.valid        <= 1'b0;
		byte_stream.in_byte      <= 8'h00;
		byte_stream.end_of_input <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hex escape cut short by a non-hex byte, a full four-digit escape at
		// the reset limit, then a backslash left pending at the end marker.
		send_text("\"\\x4g\\X007F\\", 1'b1);
		// Unknown escape; the end byte after it is ignored.
		send_text("\"\\q", 1'b0);
		send_word(8'hFF, 1'b1);
		// Hex escape with no digits before the closing quote.
		send_text("\"\\x\"", 1'b0);
		send_word(8'h00, 1'b1);
		// Hex escape finished by the end marker, above the limit.
		send_text("\"\\x80", 1'b1);
		wait_results();

		set_limit(8'hFF);
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		hold_request = 1'b1;
		run_random(60);
		wait_results();

		set_limit(8'h00);
		run_random(40);
		wait_results();

		set_limit(8'($urandom_range(1, 254)));
		run_random(50);
		wait_results();

		// Full rate on both streams to the end.
		set_limit(ESCAPE_LIMIT_RESET);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		run_random(40);
		wait_results();

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- quoted_string_unescaper.f -----
hdl/qsu_pkg.sv
hdl/qsu_if.sv
hdl/qsu_front.sv
hdl/qsu_fifo.sv
hdl/qsu_back.sv
hdl/quoted_string_unescaper.sv
tb/qsu_decode_monitor.sv
tb/tb_quoted_string_unescaper.sv
